// ===== rtl/core/psq_pkg.sv =====
// Package for the power status qualifier: widths, register indexes, reset values,
// the config struct and the power state encoding.
// No dependencies; the other files refer to it by scoped names or import it.
package psq_pkg;

	localparam int unsigned TimeW    = 32;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 2;

	localparam logic [CfgDataW-1:0] QualifyResetMs = 16'd250;
	localparam logic [CfgDataW-1:0] HoldResetMs    = 16'd1000;

	// Register indexes on the config port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_QUALIFY_TIME = 2'd0,
		CFG_HOLD_TIME    = 2'd1
	} cfg_idx_t;

	// Reported power state codes
	typedef enum logic [1:0] {
		PS_BATTERY     = 2'd0,
		PS_USB_POWERED = 2'd1,
		PS_USB_CHARGE  = 2'd2,
		PS_CHARGE_ONLY = 2'd3
	} power_state_t;

	// Status flag pair: usb present and charging after stretching
	typedef struct packed {
		logic chg;
		logic usb;
	} flags_t;

	// Config register values handed to the datapath
	typedef struct packed {
		logic [CfgDataW-1:0] qualify_ms;
		logic [CfgDataW-1:0] hold_ms;
	} cfg_t;

	function automatic power_state_t state_of(flags_t f);
		power_state_t s;
		if (f.usb && f.chg) begin
			s = PS_USB_CHARGE;
		end else if (f.usb) begin
			s = PS_USB_POWERED;
		end else if (f.chg) begin
			s = PS_CHARGE_ONLY;
		end else begin
			s = PS_BATTERY;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/psq_if.sv =====
// Handshake channels of the power status qualifier: pin samples, status results
// and config writes. Depends on psq_pkg for widths.

interface psq_sample_if;
	logic                        valid;
	logic                        ready;
	logic                        usb_pin;
	logic                        charge_pin;
	logic [psq_pkg::TimeW-1:0]   sample_time_ms;

	modport source (output valid, usb_pin, charge_pin, sample_time_ms, input ready);
	modport sink   (input valid, usb_pin, charge_pin, sample_time_ms, output ready);
endinterface

interface psq_status_if;
	logic       valid;
	logic       ready;
	logic [1:0] power_state;
	logic       usb_present;
	logic       charging_flag;

	modport source (output valid, power_state, usb_present, charging_flag, input ready);
	modport sink   (input valid, power_state, usb_present, charging_flag, output ready);
endinterface

interface psq_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [psq_pkg::CfgIdxW-1:0]    index;
	logic [psq_pkg::CfgDataW-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/power_status_qualifier.sv =====
// Top level of the power status qualifier: input stage, state update, result stage.
// Depends on psq_pkg, psq_if, psq_cfg_regs and psq_update.
//
//  port     dir   role
//  sample   sink  pin levels plus millisecond timestamp, one per transfer
//  status   src   qualified power state and flags, one per sample
//  cfg      sink  register writes (0 qualify time, 1 hold time), always ready
//
// One sample per cycle sustained while the result side is ready; a sample passes the input register,
// then the result register, before its result is valid and can transfer.
// The state update sits between the two registers.
// Reset clears all qualifier state and loads qualify 250 ms, hold 1000 ms.
// A stalled result holds; the input register still takes one more sample.
module power_status_qualifier (
	input  logic        clk,
	input  logic        arst_n,
	psq_sample_if.sink  sample,
	psq_status_if.source status,
	psq_cfg_if.sink     cfg
);

	psq_pkg::cfg_t               cfg_vals;
	psq_pkg::flags_t             qual_next;

	logic                        valid_s1;
	logic                        usb_s1;
	logic                        pulse_s1;
	logic [psq_pkg::TimeW-1:0]   time_s1;
	logic                        valid_s2;
	psq_pkg::flags_t             flags_s2;
	logic                        adv;

	psq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_vals (cfg_vals)
	);

	// Handshake: stage 1 moves on when the result register is free or drained
	assign adv          = valid_s1 && (!valid_s2 || status.ready);
	assign sample.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			usb_s1   <= sample.usb_pin;
			pulse_s1 <= sample.charge_pin;
			time_s1  <= sample.sample_time_ms;
		end
	end

	psq_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.usb       (usb_s1),
		.pulse     (pulse_s1),
		.now       (time_s1),
		.cfg_vals  (cfg_vals),
		.qual_next (qual_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (status.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2 <= qual_next;
		end
	end

	assign status.valid         = valid_s2;
	assign status.power_state   = psq_pkg::state_of(flags_s2);
	assign status.usb_present   = flags_s2.usb;
	assign status.charging_flag = flags_s2.chg;

	// Stage 1 never advances into a full, stalled result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !status.ready |-> !adv)
		else $error("result overwritten while stalled");

	// A held input item advances once the output drains
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && status.ready |-> adv)
		else $error("input stage stuck with free output");

	// Every advance yields a valid result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advance without result");

endmodule

// ===== rtl/core/psq_cfg_regs.sv =====
// Config registers of the power status qualifier (qualify and hold times).
// Depends on psq_pkg and psq_cfg_if.
module psq_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	psq_cfg_if.sink           cfg,
	output psq_pkg::cfg_t     cfg_vals
);

	psq_pkg::cfg_t cfg_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qualify_ms <= psq_pkg::QualifyResetMs;
			cfg_q.hold_ms    <= psq_pkg::HoldResetMs;
		end else if (cfg.valid) begin
			case (psq_pkg::cfg_idx_t'(cfg.index))
				psq_pkg::CFG_QUALIFY_TIME: cfg_q.qualify_ms <= cfg.data;
				psq_pkg::CFG_HOLD_TIME:    cfg_q.hold_ms    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_vals = cfg_q;

endmodule

// ===== rtl/core/psq_update.sv =====
// Hold stretching and status qualification state, updated once per transfer.
// Depends on psq_pkg; driven by the top level's input stage.
module psq_update (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        usb,
	input  logic                        pulse,
	input  logic [psq_pkg::TimeW-1:0]   now,
	input  psq_pkg::cfg_t               cfg_vals,
	output psq_pkg::flags_t             qual_next
);

	logic                        first_done_q;
	logic                        activity_q;
	logic [psq_pkg::TimeW-1:0]   last_act_q;
	psq_pkg::flags_t             cand_q;
	logic [psq_pkg::TimeW-1:0]   cand_start_q;
	psq_pkg::flags_t             qual_q;

	logic [psq_pkg::TimeW-1:0]   since_act;
	logic [psq_pkg::TimeW-1:0]   since_cand;
	logic                        hold_expired;
	logic                        activity_d;
	psq_pkg::flags_t             sampled;
	logic                        cand_change;
	logic                        qual_take;

	// Charge hold: a pulse restarts it, an expired hold drops it
	always_comb begin
		since_act    = now - last_act_q;
		hold_expired = since_act >= {{(psq_pkg::TimeW-psq_pkg::CfgDataW){1'b0}}, cfg_vals.hold_ms};
		activity_d   = pulse || (activity_q && !hold_expired);
		sampled.usb  = usb;
		sampled.chg  = pulse || (usb && activity_d);
	end

	// Candidate tracking and qualification
	always_comb begin
		since_cand  = now - cand_start_q;
		cand_change = !first_done_q || (sampled != cand_q);
		qual_take   = !cand_change && (cand_q != qual_q) &&
			(since_cand >=
			 {{(psq_pkg::TimeW-psq_pkg::CfgDataW){1'b0}}, cfg_vals.qualify_ms});
		if (!first_done_q) begin
			qual_next = sampled;
		end else if (qual_take) begin
			qual_next = cand_q;
		end else begin
			qual_next = qual_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_done_q <= 1'b0;
			activity_q   <= 1'b0;
			last_act_q   <= '0;
			cand_q       <= '0;
			cand_start_q <= '0;
			qual_q       <= '0;
		end else if (fire) begin
			first_done_q <= 1'b1;
			activity_q   <= activity_d;
			if (pulse) begin
				last_act_q <= now;
			end
			if (cand_change) begin
				cand_q       <= sampled;
				cand_start_q <= now;
			end
			qual_q <= qual_next;
		end
	end

	// State moves only on a transfer
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(qual_q) && $stable(cand_q) && $stable(activity_q))
		else $error("qualifier state changed without a transfer");

	// After the first sample, the qualified status only moves to the candidate
	a_qual_from_cand: assert property (@(posedge clk) disable iff (!arst_n)
		fire && first_done_q && (qual_next != qual_q) |-> qual_next == cand_q)
		else $error("qualified status changed to something other than the candidate");

	// First sample qualifies at once
	a_first_sample: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !first_done_q |=> first_done_q && qual_q == cand_q)
		else $error("first sample did not qualify");

	// Charging without usb is only reported while a pulse is present
	a_no_usb_stretch: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !usb && !pulse |-> !sampled.chg)
		else $error("hold stretched without usb power");

endmodule

// ===== bench/psq_qualified_status_check.sv =====
// Checker for the power status qualifier: watches the sample, status and config
// channels, predicts each status transfer and compares it field by field.
// Depends on psq_pkg and the channel interfaces in psq_if.
module psq_qualified_status_check (
	input  logic        clk,
	input  logic        arst_n,
	psq_sample_if       sample,
	psq_status_if       status,
	psq_cfg_if          cfg,
	output int unsigned in_flight,
	output int unsigned mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import psq_pkg::*;

	// One status transfer as seen on the result channel
	typedef struct packed {
		power_state_t state;
		logic         usb;
		logic         chg;
	} status_t;

	// Shadow registers and qualifier state
	logic [CfgDataW-1:0] qualify_ms;
	logic [CfgDataW-1:0] hold_ms;
	logic                seen_first;
	logic                hold_live;
	logic [TimeW-1:0]    last_pulse_ms;
	logic [TimeW-1:0]    cand_since_ms;
	flags_t              cand;
	flags_t              qual;

	status_t     owed_status[$];
	int unsigned mismatch_count = 0;

	task automatic flag_mismatch(input string msg);
		$display("[%0t] status mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Advance the qualifier by one sample and return the status it reports
	function automatic status_t next_qualified_status(logic usb, logic pulse,
			logic [TimeW-1:0] now);
		logic [TimeW-1:0] pulse_age;
		logic [TimeW-1:0] cand_age;
		flags_t           seen;
		status_t          r;
		// charge stretching: a pulse restarts the hold, expiry is unsigned
		pulse_age = now - last_pulse_ms;
		if (pulse) begin
			hold_live     = 1'b1;
			last_pulse_ms = now;
		end else if (hold_live && pulse_age >= TimeW'(hold_ms)) begin
			hold_live = 1'b0;
		end
		seen.usb = usb;
		seen.chg = pulse || (usb && hold_live);

		// candidate tracking and qualification
		cand_age = now - cand_since_ms;
		if (!seen_first) begin
			cand          = seen;
			qual          = seen;
			cand_since_ms = now;
			seen_first    = 1'b1;
		end else if (seen != cand) begin
			cand          = seen;
			cand_since_ms = now;
		end else if (cand != qual && cand_age >= TimeW'(qualify_ms)) begin
			qual = cand;
		end

		case ({qual.usb, qual.chg})
			2'b11:   r.state = PS_USB_CHARGE;
			2'b10:   r.state = PS_USB_POWERED;
			2'b01:   r.state = PS_CHARGE_ONLY;
			default: r.state = PS_BATTERY;
		endcase
		r.usb = qual.usb;
		r.chg = qual.chg;
		return r;
	endfunction

	// Channel monitor: config, then result compare, then new expectation
	always @(posedge clk or negedge arst_n) begin
		status_t got;
		status_t want;
		if (!arst_n) begin
			qualify_ms    = QualifyResetMs;
			hold_ms       = HoldResetMs;
			seen_first    = 1'b0;
			hold_live     = 1'b0;
			last_pulse_ms = '0;
			cand_since_ms = '0;
			cand          = '0;
			qual          = '0;
			owed_status.delete();
			in_flight <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_QUALIFY_TIME: qualify_ms = cfg.data;
					CFG_HOLD_TIME:    hold_ms = cfg.data;
					default: ;  // spare indexes are ignored
				endcase
			end

			if (status.valid && status.ready) begin
				got.state = power_state_t'(status.power_state);
				got.usb   = status.usb_present;
				got.chg   = status.charging_flag;
				if (owed_status.size() == 0) begin
					flag_mismatch("result transfer with nothing expected");
				end else begin
					want = owed_status.pop_front();
					if (got.state !== want.state) begin
						flag_mismatch($sformatf("power_state %0d, expected %0d",
							status.power_state, want.state));
					end
					if (got.usb !== want.usb) begin
						flag_mismatch($sformatf("usb_present %b, expected %b",
							got.usb, want.usb));
					end
					if (got.chg !== want.chg) begin
						flag_mismatch($sformatf("charging_flag %b, expected %b",
							got.chg, want.chg));
					end
				end
			end

			if (sample.valid && sample.ready) begin
				owed_status.push_back(next_qualified_status(sample.usb_pin,
					sample.charge_pin, sample.sample_time_ms));
			end
			in_flight <= owed_status.size();
		end
		mismatches <= mismatch_count;
	end

endmodule

// ===== bench/power_status_qualifier_test.sv =====
// Testbench top for the power status qualifier: clock, reset, sample and config
// stimulus, result backpressure and the verdict.
// Depends on psq_pkg, psq_if, the block itself and psq_qualified_status_check.
module power_status_qualifier_test;
	timeunit 1ns;
	timeprecision 1ps;
	import psq_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned StallCycles = 64;
	localparam int unsigned IdlePct     = 18;
	localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

	logic        clk;
	logic        arst_n;
	int unsigned in_flight;
	int unsigned mismatches;
	int unsigned cycle_count = 0;
	logic        no_idle     = 1'b0;
	logic        stall_req   = 1'b0;

	// timing currently programmed, used to aim timestamps at the boundaries
	logic [CfgDataW-1:0] cur_qualify = QualifyResetMs;
	logic [CfgDataW-1:0] cur_hold    = HoldResetMs;

	psq_sample_if sample ();
	psq_status_if status ();
	psq_cfg_if    cfg ();

	power_status_qualifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.status (status),
		.cfg    (cfg)
	);

	psq_qualified_status_check qual_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.status     (status),
		.cfg        (cfg),
		.in_flight  (in_flight),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CycleLimit) begin
				$display("** power_status_qualifier: FAILED **");
				$finish;
			end
		end
	end

	// Result side: random stalls, or one long hold-off on request
	initial begin
		status.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				status.ready <= 1'b0;
				repeat (StallCycles) @(posedge clk);
			end else begin
				status.ready <= no_idle || ($urandom_range(99) >= IdlePct);
			end
		end
	end

	// One sample transfer, then maybe a few idle cycles
	task automatic send_sample(input logic usb, input logic pulse,
			input logic [TimeW-1:0] t);
		sample.valid          <= 1'b1;
		sample.usb_pin        <= usb;
		sample.charge_pin     <= pulse;
		sample.sample_time_ms <= t;
		do @(posedge clk); while (!sample.ready);
		if (!no_idle) begin
			while ($urandom_range(99) < IdlePct) begin
				sample.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every owed result has come back
	task automatic drain();
		sample.valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	// One register write; valid stays up when more writes follow
	task automatic write_reg(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] val, input logic last);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (last) begin
			cfg.valid <= 1'b0;
		end
	endtask

	task automatic set_timing(input logic [CfgDataW-1:0] q, input logic [CfgDataW-1:0] h);
		write_reg(CFG_QUALIFY_TIME, q, 1'b0);
		write_reg(CFG_HOLD_TIME, h, 1'b1);
		cur_qualify = q;
		cur_hold    = h;
	endtask

	// Random samples: pin levels in runs, timestamps mostly stepping forward, some steps
	// onto or just short of the qualify and hold boundaries, some repeats, some jumps
	task automatic run_phase(input int unsigned n_items);
		logic             usb;
		logic             pulse;
		logic [TimeW-1:0] t;
		int unsigned      sel;
		int unsigned      span;
		usb   = 1'($urandom_range(1));
		pulse = 1'($urandom_range(1));
		t     = $urandom();
		span  = (cur_qualify > cur_hold ? cur_qualify : cur_hold) / 3 + 2;
		for (int unsigned i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 15) usb = ~usb;
			if ($urandom_range(99) < 20) pulse = ~pulse;
			sel = $urandom_range(99);
			if (sel < 4) begin
				t = $urandom();  // jump, often backwards
			end else if (sel < 14) begin
				t = t + cur_qualify;
			end else if (sel < 20) begin
				t = t + cur_qualify - 1;
			end else if (sel < 30) begin
				t = t + cur_hold;
			end else if (sel < 36) begin
				t = t + cur_hold - 1;
			end else if (sel < 44) begin
				t = t;  // same timestamp again
			end else begin
				t = t + $urandom_range(span);
			end
			send_sample(usb, pulse, t);
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n = 1'b0;
		sample.valid          <= 1'b0;
		sample.usb_pin        <= 1'b0;
		sample.charge_pin     <= 1'b0;
		sample.sample_time_ms <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_QUALIFY_TIME;
		cfg.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset timing: first sample qualifies at once, then stretch and qualify
		send_sample(1'b1, 1'b0, 32'd0);
		send_sample(1'b1, 1'b1, 32'd100);
		send_sample(1'b1, 1'b1, 32'd349);
		send_sample(1'b1, 1'b1, 32'd350);
		send_sample(1'b1, 1'b0, 32'd1349);  // still held
		send_sample(1'b1, 1'b0, 32'd1350);  // hold expires
		send_sample(1'b1, 1'b0, 32'd1600);
		send_sample(1'b0, 1'b1, 32'd2000);  // charge without usb
		send_sample(1'b0, 1'b1, 32'd2250);
		send_sample(1'b0, 1'b0, 32'd2300);  // held activity ignored without usb
		send_sample(1'b0, 1'b0, 32'd2550);
		send_sample(1'b1, 1'b0, 32'd2600);  // held activity counts again with usb
		send_sample(1'b1, 1'b1, 32'hFFFF_FF80);
		send_sample(1'b1, 1'b0, 32'hFFFF_FFFF);
		send_sample(1'b0, 1'b0, 32'h0000_0050);  // timestamp wraps
		send_sample(1'b0, 1'b0, 32'h0000_0010);  // timestamp goes backwards
		drain();

		// zero qualify and hold; spare indexes must be ignored
		write_reg(CFG_QUALIFY_TIME, '0, 1'b0);
		write_reg(CFG_HOLD_TIME, '0, 1'b0);
		write_reg(CfgSpareLo, CfgDataW'($urandom()), 1'b0);
		write_reg(CfgSpareHi, CfgDataW'($urandom()), 1'b1);
		cur_qualify = '0;
		cur_hold    = '0;
		send_sample(1'b1, 1'b1, 32'd500);
		send_sample(1'b1, 1'b0, 32'd500);  // zero hold clears on first non-pulse
		send_sample(1'b1, 1'b0, 32'd500);  // zero qualify reports on second sample
		send_sample(1'b0, 1'b1, 32'd501);
		send_sample(1'b0, 1'b1, 32'd501);
		drain();

		set_timing('1, '1);
		run_phase(150);
		drain();

		set_timing('0, '0);
		run_phase(200);
		drain();

		// no idling, with one long result hold-off so the input backs up
		set_timing(CfgDataW'($urandom_range(20)), CfgDataW'($urandom_range(40)));
		no_idle   = 1'b1;
		stall_req = 1'b1;
		run_phase(300);
		no_idle = 1'b0;
		drain();

		set_timing(CfgDataW'($urandom()), CfgDataW'($urandom()));
		run_phase(200);
		drain();

		set_timing(QualifyResetMs, HoldResetMs);
		run_phase(250);
		drain();

		set_timing(CfgDataW'($urandom_range(20)), CfgDataW'($urandom_range(40)));
		run_phase(300);
		drain();

		set_timing(CfgDataW'($urandom_range(300)), CfgDataW'($urandom_range(300)));
		run_phase(420);
		drain();

		// settle past the pipeline depth so stray results get seen
		repeat (8) @(posedge clk);
		if (mismatches == 0 && in_flight == 0) begin
			$display("** power_status_qualifier: PASSED **");
		end else begin
			$display("** power_status_qualifier: FAILED **");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/psq_pkg.sv
rtl/core/psq_if.sv
rtl/core/psq_cfg_regs.sv
rtl/core/psq_update.sv
rtl/core/power_status_qualifier.sv
bench/psq_qualified_status_check.sv
bench/power_status_qualifier_test.sv
